### src/iga_pkg.sv
// ----------------------------------------------------------------------------
// iga_pkg
// shared types and constants of the imu gyro/accel time aligner
// ----------------------------------------------------------------------------
package iga_pkg;

	localparam int TIME_W          = 48;
	localparam int AXIS_W          = 16;
	localparam int GYRO_DEPTH_DEF  = 16;
	localparam int ACCEL_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
	// interpolation quotient saturates at 2**QUOT_W - 1
	localparam int QUOT_W          = 17;

	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef axis_t [2:0] vec_t;

	// time in the low bits, then x, y, z
	typedef struct packed {
		vec_t              v;
		logic [TIME_W-1:0] t;
	} entry_t;

	typedef enum logic {
		OP_GYRO  = 1'b0,
		OP_ACCEL = 1'b1
	} op_t;

	// one interpolation job: rate at ta on the line through (t0, w0) and (t1, w1)
	typedef struct packed {
		logic [TIME_W-1:0] t0;
		logic [TIME_W-1:0] t1;
		logic [TIME_W-1:0] ta;
		vec_t              w0;
		vec_t              w1;
	} interp_req_t;

endpackage

### src/imu_gyro_accel_time_aligner.sv
// ----------------------------------------------------------------------------
// imu_gyro_accel_time_aligner
// merges gyro and accel samples, gyro rate interpolated at accel times
//
//  channel  dir  tdata (low bit up)                              tuser/tlast
//  s_*      in   sample_time, axis_x, axis_y, axis_z (96 b)      tuser = op
//  m_*      out  merged_time, rate_x/y/z, accel_x/y/z (144 b)    tlast = last
//
//  a gyro item with no release is checked against the oldest pending accel, if any, and pushed
//  each interpolated result uses the shared interpolator:
//  three axes of up to 16 multiply steps and 17 divide steps
//  an accel item pops each stored gyro entry it has passed and runs one
//  interpolation when it lands between stored gyro samples
//  reset empties both queues at once, no clearing pass
//  a stalled m_tready holds the sequencer in its emit state
// ----------------------------------------------------------------------------
module imu_gyro_accel_time_aligner #(
	parameter int GYRO_DEPTH  = iga_pkg::GYRO_DEPTH_DEF,
	parameter int ACCEL_DEPTH = iga_pkg::ACCEL_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // sample_time, axis_x, axis_y, axis_z
	input  logic         s_tuser,   // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // merged_time, rate_x/y/z, accel_x/y/z
	output logic         m_tlast    // last_of_run
);
	import iga_pkg::*;

	localparam int GAW = (GYRO_DEPTH > 1) ? $clog2(GYRO_DEPTH) : 1;
	localparam int GCW = $clog2(GYRO_DEPTH + 1);
	localparam int AAW = (ACCEL_DEPTH > 1) ? $clog2(ACCEL_DEPTH) : 1;
	localparam int ACW = $clog2(ACCEL_DEPTH + 1);
	localparam int EW  = $bits(entry_t);

	typedef enum logic [3:0] {
		T_IDLE, T_DISP, G_ACHK, G_G0, T_INT, T_WAIT, G_ANEXT, G_TRIM_RD,
		G_TRIM_CHK, G_PUSH, A_G0, A_GB, A_G1, A_G1RD, T_EMIT
	} state_t;

	function automatic logic [GAW-1:0] gidx(input logic [GAW-1:0] h,
		input logic [GCW-1:0] off);
		logic [GCW:0] sum;
		sum = (GCW+1)'(h) + (GCW+1)'(off);
		if (sum >= (GCW+1)'(GYRO_DEPTH)) begin
			sum = sum - (GCW+1)'(GYRO_DEPTH);
		end
		return sum[GAW-1:0];
	endfunction

	function automatic logic [AAW-1:0] aidx(input logic [AAW-1:0] h,
		input logic [ACW-1:0] off);
		logic [ACW+AAW:0] sum;
		sum = (ACW+AAW+1)'(h) + (ACW+AAW+1)'(off);
		if (sum >= (ACW+AAW+1)'(ACCEL_DEPTH)) begin
			sum = sum - (ACW+AAW+1)'(ACCEL_DEPTH);
		end
		return sum[AAW-1:0];
	endfunction

	state_t               state_q;
	op_t                  op_q;
	entry_t               s_q;
	entry_t               a_q;
	entry_t               g0_q;
	entry_t               g1_q;
	logic [GAW-1:0]       gh_q;
	logic [GCW-1:0]       gc_q;
	logic [AAW-1:0]       ah_q;
	logic [ACW-1:0]       ac_q;
	logic [RES_CNT_W-1:0] n_q;
	logic                 cont_q;
	logic                 last_q;
	logic [TIME_W-1:0]    rt_q;
	vec_t                 rr_q;
	vec_t                 ra_q;
	logic                 out_valid_q;
	logic [143:0]         out_data_q;
	logic                 out_last_q;

	logic                 g_we;
	logic [GAW-1:0]       g_waddr;
	logic [GAW-1:0]       g_raddr;
	logic [EW-1:0]        g_rd_raw;
	entry_t               g_rd;
	logic                 a_we;
	logic [AAW-1:0]       a_waddr;
	logic [AAW-1:0]       a_raddr;
	logic [EW-1:0]        a_rd_raw;
	entry_t               a_rd;
	logic                 i_start;
	interp_req_t          i_req;
	logic                 i_done;
	vec_t                 i_rate;
	logic                 out_free;

	assign g_rd = entry_t'(g_rd_raw);
	assign a_rd = entry_t'(a_rd_raw);

	// accesses are sequenced: a write ends the item, so no read overlaps it
	always_comb begin
		g_we    = (state_q == G_PUSH);
		g_waddr = gidx(gh_q, gc_q);
		unique case (state_q)
			A_G0:         g_raddr = gidx(gh_q, GCW'(gc_q - 1'b1));
			A_GB, A_G1RD: g_raddr = gidx(gh_q, GCW'(1));
			default:      g_raddr = gh_q;
		endcase
		a_we    = (state_q == A_GB) && (s_q.t > g_rd.t) && (ac_q < ACW'(ACCEL_DEPTH));
		a_waddr = aidx(ah_q, ac_q);
		a_raddr = (state_q == T_WAIT) ? aidx(ah_q, ACW'(1)) : ah_q;
	end

	always_comb begin
		i_start  = (state_q == T_INT);
		i_req.t0 = g0_q.t;
		i_req.w0 = g0_q.v;
		i_req.t1 = (op_q == OP_GYRO) ? s_q.t : g1_q.t;
		i_req.w1 = (op_q == OP_GYRO) ? s_q.v : g1_q.v;
		i_req.ta = (op_q == OP_GYRO) ? a_q.t : s_q.t;
		out_free = !out_valid_q || m_tready;
	end

	iga_ram #(.WIDTH(EW), .DEPTH(GYRO_DEPTH)) u_gyro_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (s_q),
		.raddr (g_raddr),
		.rdata (g_rd_raw)
	);

	iga_ram #(.WIDTH(EW), .DEPTH(ACCEL_DEPTH)) u_accel_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (s_q),
		.raddr (a_raddr),
		.rdata (a_rd_raw)
	);

	iga_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (i_start),
		.req    (i_req),
		.done   (i_done),
		.rate   (i_rate)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			gh_q        <= '0;
			gc_q        <= '0;
			ah_q        <= '0;
			ac_q        <= '0;
			n_q         <= '0;
			cont_q      <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			op_q        <= OP_GYRO;
		end else begin
			if ((state_q == T_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (s_tvalid) begin
						s_q     <= entry_t'(s_tdata);
						op_q    <= op_t'(s_tuser);
						state_q <= T_DISP;
					end
				end
				T_DISP: begin
					n_q <= '0;
					if (op_q == OP_GYRO) begin
						state_q <= (ac_q != '0) ? G_ACHK : G_PUSH;
					end else begin
						state_q <= (gc_q != '0) ? A_G0 : T_IDLE;
					end
				end
				G_ACHK: begin
					a_q <= a_rd;
					if (s_q.t < a_rd.t) begin
						// gyro older than the oldest pending accel
						gc_q    <= '0;
						state_q <= G_PUSH;
					end else if (gc_q != '0) begin
						state_q <= G_G0;
					end else begin
						g0_q    <= s_q;
						state_q <= T_INT;
					end
				end
				G_G0: begin
					g0_q    <= g_rd;
					state_q <= T_INT;
				end
				T_INT: begin
					state_q <= T_WAIT;
				end
				T_WAIT: begin
					if (i_done) begin
						rr_q   <= i_rate;
						cont_q <= 1'b0;
						last_q <= 1'b1;
						if (op_q == OP_GYRO) begin
							rt_q    <= a_q.t;
							ra_q    <= a_q.v;
							ah_q    <= aidx(ah_q, ACW'(1));
							ac_q    <= ac_q - 1'b1;
							n_q     <= n_q + 1'b1;
							state_q <= (ac_q > ACW'(1)) ? G_ANEXT : T_EMIT;
						end else begin
							rt_q    <= s_q.t;
							ra_q    <= s_q.v;
							state_q <= T_EMIT;
						end
					end
				end
				G_ANEXT: begin
					a_q     <= a_rd;
					cont_q  <= (n_q < RES_CNT_W'(MAX_RESULTS)) && (s_q.t >= a_rd.t);
					last_q  <= !((n_q < RES_CNT_W'(MAX_RESULTS)) && (s_q.t >= a_rd.t));
					state_q <= T_EMIT;
				end
				T_EMIT: begin
					if (out_free) begin
						out_data_q  <= {ra_q, rr_q, rt_q};
						out_last_q  <= last_q;
						if (cont_q) begin
							state_q <= T_INT;
						end else if (op_q == OP_GYRO) begin
							state_q <= (ac_q != '0) ? G_TRIM_RD : G_PUSH;
						end else begin
							state_q <= T_IDLE;
						end
					end
				end
				G_TRIM_RD: begin
					state_q <= (gc_q != '0) ? G_TRIM_CHK : G_PUSH;
				end
				G_TRIM_CHK: begin
					if (g_rd.t < s_q.t) begin
						gh_q    <= gidx(gh_q, GCW'(1));
						gc_q    <= gc_q - 1'b1;
						state_q <= G_TRIM_RD;
					end else begin
						state_q <= G_PUSH;
					end
				end
				G_PUSH: begin
					// full queue: the write lands on the oldest entry
					if (gc_q == GCW'(GYRO_DEPTH)) begin
						gh_q <= gidx(gh_q, GCW'(1));
					end else begin
						gc_q <= gc_q + 1'b1;
					end
					state_q <= T_IDLE;
				end
				A_G0: begin
					g0_q    <= g_rd;
					state_q <= (s_q.t < g_rd.t) ? T_IDLE : A_GB;
				end
				A_GB: begin
					if (s_q.t > g_rd.t) begin
						gh_q <= gidx(gh_q, GCW'(gc_q - 1'b1));
						gc_q <= GCW'(1);
						if (ac_q < ACW'(ACCEL_DEPTH)) begin
							ac_q <= ac_q + 1'b1;
						end
						state_q <= T_IDLE;
					end else if (s_q.t == g_rd.t) begin
						gh_q    <= gidx(gh_q, GCW'(gc_q - 1'b1));
						gc_q    <= GCW'(1);
						rt_q    <= s_q.t;
						rr_q    <= g_rd.v;
						ra_q    <= s_q.v;
						cont_q  <= 1'b0;
						last_q  <= 1'b1;
						state_q <= T_EMIT;
					end else begin
						state_q <= A_G1;
					end
				end
				A_G1: begin
					if ((gc_q > GCW'(2)) && (s_q.t >= g_rd.t)) begin
						g0_q    <= g_rd;
						gh_q    <= gidx(gh_q, GCW'(1));
						gc_q    <= gc_q - 1'b1;
						state_q <= A_G1RD;
					end else begin
						g1_q    <= g_rd;
						state_q <= T_INT;
					end
				end
				A_G1RD: begin
					state_q <= A_G1;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == T_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	a_gc_range: assert property (@(posedge clk) disable iff (!arst_n)
		gc_q <= GCW'(GYRO_DEPTH))
		else $error("gyro count above depth");
	a_ac_range: assert property (@(posedge clk) disable iff (!arst_n)
		ac_q <= ACW'(ACCEL_DEPTH))
		else $error("accel count above depth");
	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RES_CNT_W'(MAX_RESULTS))
		else $error("too many results for one item");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		i_done |-> state_q == T_WAIT)
		else $error("interpolation finished outside wait state");

endmodule

### src/iga_ram.sv
// ----------------------------------------------------------------------------
// iga_ram
// single port write, single port read memory with registered read data
// ----------------------------------------------------------------------------
module iga_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/iga_interp.sv
// ----------------------------------------------------------------------------
// iga_interp
// linear interpolation of three gyro axes, one axis at a time, with a
// shift-add multiplier and a restoring divider
// ----------------------------------------------------------------------------
module iga_interp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  iga_pkg::interp_req_t req,
	output logic                done,
	output iga_pkg::vec_t       rate
);
	import iga_pkg::*;

	localparam int PROD_W = TIME_W + AXIS_W;
	localparam int SUM_W  = QUOT_W + 2;

	typedef enum logic [2:0] {
		I_IDLE, I_PREP, I_AXIS, I_MUL, I_CHK, I_DIV, I_FIN
	} istate_t;

	istate_t             state_q;
	interp_req_t         req_q;
	logic [TIME_W-1:0]   un_q;
	logic [TIME_W-1:0]   uden_q;
	logic                nsgn_q;
	logic                dz_q;
	logic                dneg_q;
	logic [1:0]          k_q;
	logic [4:0]          cnt_q;
	logic [PROD_W-1:0]   mcand_q;
	logic [AXIS_W-1:0]   mplier_q;
	logic [PROD_W-1:0]   prod_q;
	logic [PROD_W-1:0]   dv_q;
	logic [QUOT_W-1:0]   quot_q;
	vec_t                rate_q;
	logic                done_q;

	logic [TIME_W:0]     num_w;
	logic [TIME_W:0]     den_w;
	logic [TIME_W:0]     unum_w;
	logic [TIME_W:0]     uden_w;
	axis_t               w0_k;
	axis_t               w1_k;
	logic [AXIS_W:0]     d_w;
	logic [AXIS_W:0]     ud_w;
	logic [PROD_W:0]     thr_w;
	logic [SUM_W-1:0]    w0e_w;
	logic [SUM_W-1:0]    qe_w;
	logic [SUM_W-1:0]    sum_w;
	axis_t               sat_w;
	logic                fin_w;

	always_comb begin
		num_w  = {1'b0, req_q.ta} - {1'b0, req_q.t0};
		den_w  = {1'b0, req_q.t1} - {1'b0, req_q.t0};
		unum_w = num_w[TIME_W] ? (~num_w + 1'b1) : num_w;
		uden_w = den_w[TIME_W] ? (~den_w + 1'b1) : den_w;
		w0_k   = req_q.w0[k_q];
		w1_k   = req_q.w1[k_q];
		d_w    = {w1_k[AXIS_W-1], w1_k} - {w0_k[AXIS_W-1], w0_k};
		ud_w   = d_w[AXIS_W] ? (~d_w + 1'b1) : d_w;
		thr_w  = {uden_q, {QUOT_W{1'b0}}};
		w0e_w  = {{(SUM_W-AXIS_W){w0_k[AXIS_W-1]}}, w0_k};
		qe_w   = SUM_W'(quot_q);
		sum_w  = (nsgn_q ^ dneg_q) ? (w0e_w - qe_w) : (w0e_w + qe_w);
		if (!sum_w[SUM_W-1] && (sum_w[SUM_W-2:AXIS_W-1] != '0)) begin
			sat_w = {1'b0, {(AXIS_W-1){1'b1}}};
		end else if (sum_w[SUM_W-1] && (sum_w[SUM_W-2:AXIS_W-1] != '1)) begin
			sat_w = {1'b1, {(AXIS_W-1){1'b0}}};
		end else begin
			sat_w = sum_w[AXIS_W-1:0];
		end
		// last axis written this cycle
		fin_w  = (k_q == 2'd2) &&
			((state_q == I_FIN) || ((state_q == I_AXIS) && dz_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= I_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= fin_w;
			unique case (state_q)
				I_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= I_PREP;
					end
				end
				I_PREP: begin
					un_q    <= unum_w[TIME_W-1:0];
					uden_q  <= uden_w[TIME_W-1:0];
					nsgn_q  <= num_w[TIME_W] ^ den_w[TIME_W];
					dz_q    <= (den_w == '0);
					k_q     <= '0;
					state_q <= I_AXIS;
				end
				I_AXIS: begin
					dneg_q   <= d_w[AXIS_W];
					mcand_q  <= PROD_W'(un_q);
					mplier_q <= ud_w[AXIS_W-1:0];
					prod_q   <= '0;
					cnt_q    <= '0;
					if (dz_q) begin
						// zero span: rate is the older sample
						rate_q[k_q] <= w0_k;
						if (k_q == 2'd2) begin
							state_q <= I_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						state_q <= I_MUL;
					end
				end
				I_MUL: begin
					if (mplier_q[0]) begin
						prod_q <= prod_q + mcand_q;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == 5'(AXIS_W - 1)) begin
						state_q <= I_CHK;
					end
				end
				I_CHK: begin
					cnt_q  <= '0;
					quot_q <= '0;
					dv_q   <= PROD_W'(uden_q) << (QUOT_W - 1);
					if ({1'b0, prod_q} >= thr_w) begin
						quot_q  <= '1;
						state_q <= I_FIN;
					end else begin
						state_q <= I_DIV;
					end
				end
				I_DIV: begin
					if (prod_q >= dv_q) begin
						prod_q <= prod_q - dv_q;
						quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
					end else begin
						quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
					end
					dv_q  <= dv_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(QUOT_W - 1)) begin
						state_q <= I_FIN;
					end
				end
				I_FIN: begin
					rate_q[k_q] <= sat_w;
					if (k_q == 2'd2) begin
						state_q <= I_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= I_AXIS;
					end
				end
				default: state_q <= I_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign rate = rate_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == I_IDLE)
		else $error("interpolation started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held for more than one cycle");
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == I_DIV |-> {1'b0, prod_q} < ({1'b0, dv_q} << 1))
		else $error("divider remainder out of range");

endmodule
